// ===== rtl/mcpc_pkg.sv =====
`timescale 1ns / 1ps

package mcpc_pkg;

   // Saturation value of the click counter.
   localparam logic [7:0] CLICK_LIMIT = 8'd255;

   // Reset values of the configuration registers.
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [15:0] GAP_RESET      = 16'd600;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;
   localparam logic [7:0]  PAGES_RESET    = 8'd4;

   // Button identifiers.
   localparam logic [1:0] BUTTON_COUNTED = 2'd0;
   localparam logic [1:0] BUTTON_OTHER_A = 2'd1;
   localparam logic [1:0] BUTTON_OTHER_B = 2'd2;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_GAP      = 2'd1,
      CSR_TIMEOUT  = 2'd2,
      CSR_PAGES    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] gap_ms;
      logic [15:0] total_timeout_ms;
      logic [7:0]  page_count;
   } cfg_type;

   // Payload of one input transfer.
   typedef struct packed {
      logic [31:0] now_ms;
      logic        pressed;
      logic [1:0]  button_id;
      cmd_type     cmd;
   } req_item_type;

   // Result item; finished sits in the lowest bit.
   typedef struct packed {
      logic [7:0] page_number;
      logic       page_valid;
      logic       other_key_seen;
      logic [7:0] click_total;
      logic       finished;
   } rsp_item_type;

   localparam int RSP_BITS = $bits(rsp_item_type);

endpackage

// ===== rtl/mcpc_step.sv =====
`timescale 1ns / 1ps

module mcpc_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  mcpc_pkg::req_item_type item,
   input  mcpc_pkg::cfg_type      cfg,
   output mcpc_pkg::rsp_item_type result
);
   import mcpc_pkg::*;

   // Session state, updated once per item that moves to the result register.
   logic        active_ff,   active_in;
   logic        done_ff,     done_in;
   logic        key_down_ff, key_down_in;
   logic        other_ff,    other_in;
   logic [7:0]  clicks_ff,   clicks_in;
   logic [31:0] start_ff,    start_in;
   logic [31:0] edge_ff,     edge_in;
   logic [31:0] release_ff,  release_in;

   logic [31:0] since_edge;
   logic [31:0] since_start;
   logic [31:0] since_release;
   logic        running;

   assign since_edge    = item.now_ms - edge_ff;
   assign since_start   = item.now_ms - start_ff;
   assign since_release = item.now_ms - release_ff;
   assign running       = active_ff && !done_ff;

   always_comb begin
      active_in   = active_ff;
      done_in     = done_ff;
      key_down_in = key_down_ff;
      other_in    = other_ff;
      clicks_in   = clicks_ff;
      start_in    = start_ff;
      edge_in     = edge_ff;
      release_in  = release_ff;
      case (item.cmd)
         CMD_START: begin
            active_in   = 1'b1;
            done_in     = 1'b0;
            key_down_in = 1'b1;
            other_in    = 1'b0;
            clicks_in   = 8'd1;
            start_in    = item.now_ms;
            edge_in     = item.now_ms;
            release_in  = item.now_ms;
         end
         CMD_SAMPLE: begin
            if (running) begin
               if (item.button_id != BUTTON_COUNTED) begin
                  if ((item.button_id == BUTTON_OTHER_A || item.button_id == BUTTON_OTHER_B)
                      && item.pressed) begin
                     other_in = 1'b1;
                  end
               end else if (item.pressed != key_down_ff &&
                            since_edge >= {16'd0, cfg.debounce_ms}) begin
                  key_down_in = item.pressed;
                  edge_in     = item.now_ms;
                  if (item.pressed) begin
                     if (clicks_ff != CLICK_LIMIT) begin
                        clicks_in = clicks_ff + 8'd1;
                     end
                  end else begin
                     release_in = item.now_ms;
                  end
               end
            end
         end
         CMD_TICK: begin
            if (running) begin
               if (since_start >= {16'd0, cfg.total_timeout_ms}) begin
                  done_in = 1'b1;
               end else if (clicks_ff != 8'd0 && !key_down_ff &&
                            since_release >= {16'd0, cfg.gap_ms}) begin
                  done_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // The result reflects the state after this item is applied.
   always_comb begin
      result.finished       = done_in;
      result.click_total    = clicks_in;
      result.other_key_seen = other_in;
      result.page_valid     = (clicks_in != 8'd0) && (clicks_in <= cfg.page_count);
      result.page_number    = result.page_valid ? clicks_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         done_ff     <= 1'b0;
         key_down_ff <= 1'b0;
         other_ff    <= 1'b0;
         clicks_ff   <= 8'd0;
         start_ff    <= 32'd0;
         edge_ff     <= 32'd0;
         release_ff  <= 32'd0;
      end else if (take) begin
         active_ff   <= active_in;
         done_ff     <= done_in;
         key_down_ff <= key_down_in;
         other_ff    <= other_in;
         clicks_ff   <= clicks_in;
         start_ff    <= start_in;
         edge_ff     <= edge_in;
         release_ff  <= release_in;
      end
   end

endmodule

// ===== rtl/multi_click_page_collector_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                        Contents
// req       in         req_tvalid/tready/tdata/user  one button sample, tick or start command
// rsp       out        rsp_tvalid/tready/tdata       session status after each item
// csr       in         csr_we/index/wdata            timing and page count registers
//
// Every request transfer yields exactly one response transfer, in order.
// An item is held in the input register and is then evaluated in one
// pass into the result register; one item per cycle is sustained as long as the
// response side takes transfers. A stalled response holds its register and the
// input register fills, after which req_tready drops. Reset is synchronous and
// clears the valid flags, the session state and the configuration registers to their defaults.

module multi_click_page_collector_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata bits from the lowest: button_id[1:0], pressed[2], now_ms[34:3], zero fill
   input  logic [39:0] req_tdata,
   // tuser: cmd[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata bits from the lowest: finished[0], click_total[8:1], other_key_seen[9],
   // page_valid[10], page_number[18:11], zero fill
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import mcpc_pkg::*;

   cfg_type      cfg_ff;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type step_result;
   logic         advance;
   logic         req_take;

   // The evaluated item moves on when the result register is free or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.cmd       <= cmd_type'(req_tuser);
         in_item_ff.button_id <= req_tdata[1:0];
         in_item_ff.pressed   <= req_tdata[2];
         in_item_ff.now_ms    <= req_tdata[34:3];
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   // Configuration registers; writes must come only while idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= DEBOUNCE_RESET;
         cfg_ff.gap_ms           <= GAP_RESET;
         cfg_ff.total_timeout_ms <= TIMEOUT_RESET;
         cfg_ff.page_count       <= PAGES_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE: cfg_ff.debounce_ms      <= csr_wdata;
            CSR_GAP:      cfg_ff.gap_ms           <= csr_wdata;
            CSR_TIMEOUT:  cfg_ff.total_timeout_ms <= csr_wdata;
            CSR_PAGES:    cfg_ff.page_count       <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   mcpc_step u_step (
      .clock  (clock),
      .reset  (reset),
      .take   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(24 - RSP_BITS)'(0), out_item_ff};

`ifndef SYNTH
   // A held input item with a stalled result register must block new transfers.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while both stages are full");

   // A valid page always equals a nonzero click total.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[18:11] == rsp_tdata[8:1]
                                      && rsp_tdata[8:1] != 8'd0)
      else $error("page number disagrees with click total");

   // After reset no result is offered.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
